[rtl/lruoc_pkg.sv]
// ----------------------------------------------------------------------------
// lruoc_pkg
// Shared widths, codes, controller states and the command and status bundles
// that join the controller to the datapath of the object cache tag store.
// ----------------------------------------------------------------------------
package lruoc_pkg;

    // Default configuration of the tag store.
    localparam int ENTRIES_DEF    = 10;
    localparam int KEY_BITS_DEF   = 64;
    localparam int STAMP_BITS_DEF = 32;

    // Field widths on the ports.
    localparam int KEY_W  = 64;
    localparam int SIZE_W = 17;
    localparam int SLOT_W = 4;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((KEY_W + SIZE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + SIZE_W + 7) / 8) * 8;

    // Reset value of the largest accepted object size.
    localparam logic [SIZE_W-1:0] MAX_OBJECT_RESET = 17'd102400;

    // Operation codes carried on the input tuser bit.
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_STORE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } lruoc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic out_load;
    } lruoc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lruoc_status_t;

endpackage

[rtl/lru_object_cache_tags_core.sv]
// ----------------------------------------------------------------------------
// lru_object_cache_tags_core
// Fully associative tag store for an object cache with timestamp LRU.
// ----------------------------------------------------------------------------
// Each input item is one operation, a lookup or a store, and yields exactly one
// result item. A lookup returns the lowest-index valid line whose key matches,
// with its size, and restamps that line from a wrapping use clock. A store with
// a size from 1 up to max_object_bytes fills the first free line, or else the
// line with the smallest stamp (lowest index on a tie), and reports the slot;
// any other size is refused and changes nothing. Duplicate keys are not
// checked. One item is worked on at a time, and its result goes to the
// output register only once the previous result has been taken. The scan
// sets the time per item: it reads one line per cycle through the single
// read port of the line memories and compares on the registered read data.
// A finished result waits in the output register, so the next item is taken
// while it is still pending. The configuration write may be issued only
// while no item is in flight; it is always accepted.
module lru_object_cache_tags_core
    import lruoc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key[63:0], obj_size[80:64], zero fill
    input  logic                 s_tuser,   // kind[0]: lookup or store

    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // slot[3:0], found_size[20:4], zero fill
    output logic [1:0]           m_tuser,   // hit[0], stored[1]

    // Configuration write of max_object_bytes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SIZE_W-1:0]    cfg_data
);

    lruoc_cmd_t        cmd;
    lruoc_status_t     status;
    logic              out_hit;
    logic              out_stored;
    logic [SLOT_W-1:0] out_slot;
    logic [SIZE_W-1:0] out_size;

    // The register takes a write in every cycle.
    assign cfg_ready = 1'b1;

    lruoc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lruoc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_size    (s_tdata[KEY_W+SIZE_W-1:KEY_W]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_value  (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (out_hit),
        .out_stored (out_stored),
        .out_slot   (out_slot),
        .out_size   (out_size)
    );

    // Pack the result fields; the top bits are zero fill.
    assign m_tdata = M_TDATA_W'({out_size, out_slot});
    assign m_tuser = {out_stored, out_hit};

endmodule

[rtl/lruoc_ctrl.sv]
// ----------------------------------------------------------------------------
// lruoc_ctrl
// Sequencer for one operation: accept, scan all lines, update, hand over.
// ----------------------------------------------------------------------------
module lruoc_ctrl
    import lruoc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lruoc_status_t status,
    output lruoc_cmd_t    cmd
);

    lruoc_state_t state_reg;
    lruoc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_WRITE: begin
                cmd.write = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/lruoc_datapath.sv]
// ----------------------------------------------------------------------------
// lruoc_datapath
// Line memories, valid bits, use clock, scan compare logic and result register.
// ----------------------------------------------------------------------------
module lruoc_datapath
    import lruoc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lruoc_cmd_t        cmd,
    output lruoc_status_t     status,
    input  logic              in_kind,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [SIZE_W-1:0] in_size,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_hit,
    output logic              out_stored,
    output logic [SLOT_W-1:0] out_slot,
    output logic [SIZE_W-1:0] out_size
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    // Configuration and the operation being worked on.
    logic [SIZE_W-1:0]     max_bytes_reg;
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic                  refused_reg;

    // Line state.
    logic [ENTRIES-1:0]    valid_reg;
    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [SIZE_W-1:0]     size_mem  [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [STAMP_BITS-1:0] clock_reg;

    // Scan pipeline: address issue, then compare on registered read data.
    logic [CNT_W-1:0]      rd_cnt_reg;
    logic                  issue;
    logic [IDX_W-1:0]      rd_addr;
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [SIZE_W-1:0]     size_rd_reg;
    logic [STAMP_BITS-1:0] stamp_rd_reg;

    // Scan results.
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic [SIZE_W-1:0]     found_size_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [STAMP_BITS-1:0] min_stamp_reg;
    logic [IDX_W-1:0]      min_idx_reg;

    // Result held between the update and the output register.
    logic                  res_hit_reg;
    logic                  res_stored_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [SIZE_W-1:0]     res_size_reg;

    // Output register.
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic                  m_stored_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic [SIZE_W-1:0]     m_size_reg;

    logic                  do_hit;
    logic                  do_store;
    logic [IDX_W-1:0]      victim;
    logic [IDX_W-1:0]      stamp_idx;
    logic                  stamp_we;

    assign issue   = cmd.scan && (rd_cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    assign do_hit    = (kind_reg == KIND_LOOKUP) && found_reg;
    assign do_store  = (kind_reg == KIND_STORE) && !refused_reg;
    assign victim    = free_found_reg ? free_idx_reg : min_idx_reg;
    assign stamp_idx = do_hit ? found_idx_reg : victim;
    assign stamp_we  = cmd.write && (do_hit || do_store);

    assign status.scan_done = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free  = !m_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_OBJECT_RESET;
        end else if (cfg_we) begin
            max_bytes_reg <= cfg_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= in_kind;
            key_reg     <= KEY_BITS'(in_key);
            size_reg    <= in_size;
            refused_reg <= (in_size == '0) || (in_size > max_bytes_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
        end else begin
            if (cmd.load) begin
                rd_cnt_reg <= '0;
            end else if (issue) begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            cmp_vld_reg <= issue;
            if (issue) begin
                cmp_idx_reg <= rd_addr;
            end
        end
    end

    // Line memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.write && do_store) begin
            key_mem[victim] <= key_reg;
        end
        if (issue) begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write && do_store) begin
            size_mem[victim] <= size_reg;
        end
        if (issue) begin
            size_rd_reg <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[stamp_idx] <= clock_reg;
        end
        if (issue) begin
            stamp_rd_reg <= stamp_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            clock_reg <= '0;
        end else if (stamp_we) begin
            clock_reg <= clock_reg + STAMP_BITS'(1);
            if (do_store) begin
                valid_reg[victim] <= 1'b1;
            end
        end
    end

    // Compare stage. Strict compares keep the lowest index on a tie.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmp_vld_reg) begin
            if (!found_reg && valid_reg[cmp_idx_reg] && (key_rd_reg == key_reg)) begin
                found_reg      <= 1'b1;
                found_idx_reg  <= cmp_idx_reg;
                found_size_reg <= size_rd_reg;
            end
            if (!free_found_reg && !valid_reg[cmp_idx_reg]) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (stamp_rd_reg < min_stamp_reg)) begin
                min_stamp_reg <= stamp_rd_reg;
                min_idx_reg   <= cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            res_hit_reg    <= do_hit;
            res_stored_reg <= do_store;
            if (do_hit) begin
                res_slot_reg <= SLOT_W'(found_idx_reg);
                res_size_reg <= found_size_reg;
            end else if (do_store) begin
                res_slot_reg <= SLOT_W'(victim);
                res_size_reg <= '0;
            end else begin
                res_slot_reg <= '0;
                res_size_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hit_reg    <= res_hit_reg;
            m_stored_reg <= res_stored_reg;
            m_slot_reg   <= res_slot_reg;
            m_size_reg   <= res_size_reg;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_hit    = m_hit_reg;
    assign out_stored = m_stored_reg;
    assign out_slot   = m_slot_reg;
    assign out_size   = m_size_reg;

    // An accepted store always leaves its line valid.
    a_store_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.write && do_store) |=> valid_reg[$past(victim)])
        else $error("stored line is not valid after the update");

    // The use clock moves only when a line is stamped.
    a_clock_only_on_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        !stamp_we |=> $stable(clock_reg))
        else $error("use clock changed without a stamp");

    // A result is never both a hit and a store.
    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_stored_reg))
        else $error("result flags hit and stored together");

    // A result carries no size unless it is a hit.
    a_size_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_size_reg == '0))
        else $error("size reported on a result that is not a hit");

endmodule

[sim/lru_object_cache_tags_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_object_cache_tags_core_tb
// Self-checking bench for the LRU object cache tag store. A behavioral copy of
// the tag lines, stamps and use clock predicts every result item. Directed
// items cover field extremes, refused stores, eviction and a re-stored key.
// Random phases then run under several idling mixes and size limits, followed
// by a long output stall that backs the block up.
// ----------------------------------------------------------------------------
module lru_object_cache_tags_core_tb;
    import lruoc_pkg::*;

    localparam int LINES        = ENTRIES_DEF;
    localparam int STALL_LIMIT  = 4000;            // cycles with no handshake at all
    localparam int DRAIN_CYCLES = ENTRIES_DEF + 8; // one item's worth plus margin
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 370;
    localparam int POOL_KEYS    = 14;              // more keys than lines forces evictions
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } cache_op_t;

    typedef struct packed {
        logic              hit;
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] found_size;
    } cache_res_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = KIND_LOOKUP;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data  = '0;

    lru_object_cache_tags_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Predicted contents of the tag store.
    bit                tag_valid [LINES];
    logic [KEY_W-1:0]  tag_key   [LINES];
    logic [SIZE_W-1:0] tag_size  [LINES];
    logic [31:0]       tag_stamp [LINES];
    logic [31:0]       use_clk;
    logic [SIZE_W-1:0] size_limit;

    cache_op_t  pending_ops[$];       // items queued for the input stream
    cache_res_t expected_results[$];  // predictions waiting for their result item
    logic [KEY_W-1:0] key_pool[POOL_KEYS];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int errors        = 0;
    int items_in      = 0;
    int results_out   = 0;
    int n_hit, n_miss, n_stored, n_refused, n_evict;

    // Applies one operation to the predicted tag store and returns its result.
    function automatic cache_res_t apply_cache_op(cache_op_t op);
        cache_res_t r;
        int victim;
        bit free_found;
        r = '0;
        victim = 0;
        free_found = 1'b0;
        if (op.kind == KIND_LOOKUP) begin
            for (int i = 0; i < LINES; i++) begin
                if (tag_valid[i] && tag_key[i] == op.key) begin
                    r.hit = 1'b1;
                    r.slot = SLOT_W'(i);
                    r.found_size = tag_size[i];
                    tag_stamp[i] = use_clk;
                    use_clk++;
                    break;
                end
            end
            if (r.hit) n_hit++;
            else n_miss++;
            return r;
        end
        if (op.size == 0 || op.size > size_limit) begin
            n_refused++;
            return r;
        end
        for (int i = 0; i < LINES; i++) begin
            if (!tag_valid[i]) begin
                victim = i;
                free_found = 1'b1;
                break;
            end
        end
        if (!free_found) begin
            // Oldest stamp goes; strict compare keeps the lowest index on a tie.
            for (int i = 1; i < LINES; i++)
                if (tag_stamp[i] < tag_stamp[victim]) victim = i;
            n_evict++;
        end
        tag_key[victim] = op.key;
        tag_size[victim] = op.size;
        tag_valid[victim] = 1'b1;
        tag_stamp[victim] = use_clk;
        use_clk++;
        r.stored = 1'b1;
        r.slot = SLOT_W'(victim);
        n_stored++;
        return r;
    endfunction

    // Input stream driver: holds an offered item until it is taken, and
    // otherwise offers the next queued item unless this cycle is a gap.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            expected_results.push_back(apply_cache_op(pending_ops.pop_front()));
            items_in++;
        end
        if (!s_tvalid || s_tready) begin
            if (aresetn && pending_ops.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({pending_ops[0].size, pending_ops[0].key});
                s_tuser  <= pending_ops[0].kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: a counted hold-off takes priority over random stalls.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every taken result is matched against the oldest prediction.
    always @(posedge aclk) begin
        cache_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            results_out++;
            got.hit        = m_tuser[0];
            got.stored     = m_tuser[1];
            got.slot       = m_tdata[SLOT_W-1:0];
            got.found_size = m_tdata[SLOT_W +: SIZE_W];
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result item with nothing expected: ",
                              "hit=%0b stored=%0b slot=%0d size=%0d"},
                             got.hit, got.stored, got.slot, got.found_size);
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit || got.stored !== want.stored ||
                    got.slot !== want.slot || got.found_size !== want.found_size) begin
                    errors++;
                    if (errors <= 10)
                        $display({"ERROR: result %0d expected hit=%0b stored=%0b ",
                                  "slot=%0d size=%0d, got hit=%0b stored=%0b ",
                                  "slot=%0d size=%0d"},
                                 results_out, want.hit, want.stored, want.slot,
                                 want.found_size, got.hit, got.stored, got.slot,
                                 got.found_size);
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet, expected_results.size());
            $display("lru_object_cache_tags_core_tb failed");
            $finish;
        end
    end

    // Queues one operation; at most one further item waits behind the one offered.
    task automatic send_op(logic kind, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
        cache_op_t op;
        op.kind = kind;
        op.key  = key;
        op.size = size;
        pending_ops.push_back(op);
        while (pending_ops.size() > 1) @(posedge aclk);
    endtask

    // Waits until every item has been taken and answered, then lets the block settle.
    task automatic wait_idle();
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_size(logic [SIZE_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        size_limit = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 65) return key_pool[$urandom_range(POOL_KEYS - 1)];
        if (r < 72) return '0;
        if (r < 79) return '1;
        if (r < 86) return KEY_W'(1) << $urandom_range(KEY_W - 1);
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 72) return SIZE_W'($urandom_range(1, size_limit));
        if (r < 79) return '0;
        if (r < 86) return size_limit;
        if (r < 93) return (size_limit == SIZE_MAX) ? SIZE_MAX : size_limit + 1'b1;
        return SIZE_W'($urandom_range(0, SIZE_MAX));
    endfunction

    // Field extremes, refused sizes, filling every line, eviction and re-storing an evicted key.
    task automatic test_directed();
        send_op(KIND_LOOKUP, '0, '0);                      // lookups on an empty store
        send_op(KIND_LOOKUP, '1, SIZE_MAX);
        send_op(KIND_STORE, '0, 17'd1);                   // smallest accepted size
        send_op(KIND_STORE, '1, MAX_OBJECT_RESET);        // largest at the reset limit
        send_op(KIND_STORE, 64'h1234, '0);                // zero size is refused
        send_op(KIND_STORE, 64'h1234, MAX_OBJECT_RESET + 1'b1);
        send_op(KIND_STORE, 64'h1234, SIZE_MAX);
        send_op(KIND_LOOKUP, '0, SIZE_MAX);               // size field ignored on lookup
        send_op(KIND_LOOKUP, '1, '0);
        for (int i = 2; i < LINES; i++)
            send_op(KIND_STORE, 64'h100 + i, SIZE_W'(i * 1000 + i));
        send_op(KIND_STORE, 64'hABCD, 17'd77);            // store is full: LRU eviction
        send_op(KIND_STORE, '0, 17'd5);                   // evicted key 0 is stored again
        send_op(KIND_LOOKUP, '0, '0);                     // its new line answers
        send_op(KIND_LOOKUP, 64'h105, '0);
        send_op(KIND_LOOKUP, 64'hDEAD_BEEF, '0);
        wait_idle();
    endtask

    // Size limit at its extremes, including a limit that refuses every store.
    task automatic test_size_limits();
        write_max_size(17'd1);
        send_op(KIND_STORE, 64'h5151, 17'd1);
        send_op(KIND_STORE, 64'h5252, 17'd2);
        write_max_size(SIZE_MAX);
        send_op(KIND_STORE, 64'h5353, SIZE_MAX);
        send_op(KIND_LOOKUP, 64'h5353, '0);
        write_max_size('0);
        send_op(KIND_STORE, 64'h5454, 17'd1);
        send_op(KIND_STORE, 64'h5555, SIZE_MAX);
        send_op(KIND_LOOKUP, 64'h5151, '0);
        wait_idle();
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, logic [SIZE_W-1:0] limit);
        write_max_size(limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_op(logic'($urandom_range(1)), pick_key(), pick_size());
        wait_idle();
    endtask

    // A long hold on the result side while items keep coming: the block fills
    // its output register and its scan, then has to refuse the input.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 24; n++)
            send_op(logic'($urandom_range(1)), pick_key(), pick_size());
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < LINES; i++) begin
            tag_valid[i] = 1'b0;
            tag_key[i]   = '0;
            tag_size[i]  = '0;
            tag_stamp[i] = '0;
        end
        use_clk    = '0;
        size_limit = MAX_OBJECT_RESET;
        n_hit = 0; n_miss = 0; n_stored = 0; n_refused = 0; n_evict = 0;
        for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_size_limits();
        test_random_phase(0, 0, SIZE_MAX);
        test_random_phase(53, 0, SIZE_W'($urandom_range(1, SIZE_MAX)));
        test_random_phase(0, 53, MAX_OBJECT_RESET);
        test_random_phase(28, 28, 17'd4096);
        test_output_stall();

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display({"Covered %0d items: %0d hits, %0d misses, ",
                  "%0d stores (%0d evictions), %0d refused."},
                 items_in, n_hit, n_miss, n_stored, n_evict, n_refused);
        $display({"Size limits from 0 to the maximum, four idling mixes and a ",
                  "%0d-cycle output hold; %0d mismatches."},
                 HOLD_CYCLES, errors);
        if (errors == 0 && results_out == items_in) begin
            $display("lru_object_cache_tags_core_tb passed");
        end else begin
            $display("lru_object_cache_tags_core_tb failed");
        end
        $finish;
    end

endmodule
